### hw/rtl/fsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the frame stack averager: field widths,
// per-pixel channel sum layout and output queue sizing.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int PIX_BITS      = 16;
    localparam int MAX_PIXELS    = 1 << PIX_BITS;
    localparam int SAMPLE_BITS   = 8;
    localparam int SUM_BITS      = 16;
    localparam int FC_BITS       = 9;
    localparam int CH_COUNT      = 3;

    localparam int FIFO_DEPTH    = 32;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS      = FIFO_PTR_BITS + 1;

    localparam int CH_RED        = 0;
    localparam int CH_GREEN      = 1;
    localparam int CH_BLUE       = 2;

    typedef logic [CH_COUNT-1:0][SUM_BITS-1:0]    rgb_sum_t;
    typedef logic [CH_COUNT-1:0][SAMPLE_BITS-1:0] rgb_sample_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] index;
        rgb_sum_t            avg;
    } result_t;

endpackage : fsa_pkg
`default_nettype wire

### hw/rtl/fsa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_div
// Pipelined restoring divider for three channels: one quotient bit per
// stage, SUM_BITS stages, a new dividend every cycle.
// ----------------------------------------------------------------------------
module fsa_div
    import fsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [PIX_BITS-1:0] in_index,
    input  rgb_sum_t            in_sum,
    input  logic [FC_BITS-1:0]  divisor,
    output logic                out_valid,
    output logic [PIX_BITS-1:0] out_index,
    output rgb_sum_t            out_quo
);

    typedef struct packed {
        logic [FC_BITS-1:0]  rem;
        logic [SUM_BITS-1:0] num;
        logic [SUM_BITS-1:0] quo;
    } div_lane_t;

    function automatic div_lane_t div_step(div_lane_t l, logic [FC_BITS-1:0] d);
        logic [FC_BITS:0] trial;
        logic             ge;
        div_lane_t        r;
        trial = {l.rem, l.num[SUM_BITS-1]};
        ge    = (trial >= {1'b0, d});
        r.rem = ge ? FC_BITS'(trial - {1'b0, d}) : trial[FC_BITS-1:0];
        r.num = {l.num[SUM_BITS-2:0], 1'b0};
        r.quo = {l.quo[SUM_BITS-2:0], ge};
        return r;
    endfunction

    logic                valid_reg [SUM_BITS];
    logic [PIX_BITS-1:0] index_reg [SUM_BITS];
    div_lane_t           lane_reg  [SUM_BITS][CH_COUNT];
    div_lane_t           lane_next [SUM_BITS][CH_COUNT];

    always_comb
    begin
        div_lane_t src;
        for (int s = 0; s < SUM_BITS; s++)
        begin
            for (int c = 0; c < CH_COUNT; c++)
            begin
                if (s == 0)
                begin
                    src.rem = '0;
                    src.num = in_sum[c];
                    src.quo = '0;
                end
                else
                begin
                    src = lane_reg[s-1][c];
                end
                lane_next[s][c] = div_step(src, divisor);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SUM_BITS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < SUM_BITS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg     <= lane_next;
        index_reg[0] <= in_index;
        for (int s = 1; s < SUM_BITS; s++)
        begin
            index_reg[s] <= index_reg[s-1];
        end
    end

    assign out_valid = valid_reg[SUM_BITS-1];
    assign out_index = index_reg[SUM_BITS-1];

    always_comb
    begin
        for (int c = 0; c < CH_COUNT; c++)
        begin
            out_quo[c] = lane_reg[SUM_BITS-1][c].quo;
        end
    end

endmodule : fsa_div
`default_nettype wire

### hw/rtl/frame_stack_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_stack_averager
// Temporal frame stacking: per-pixel RGB sums kept in a synchronous RAM,
// loaded on the first frame, accumulated with saturation after that, and
// divided by the frame count on the final frame.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  pixel in | in_valid / in_stall       | pixel_index, red/green/blue_in,
//           |                           | first_frame, final_frame
//  average  | out_valid / out_stall     | pixel_index_out, red/green/blue_avg
//  config   | cfg_wr_en                 | cfg_wr_data (frame count)
//
//  One pixel per cycle while in_stall is low. A final-frame average reaches
//  the output after its transfer as follows: the sum update shares a cycle
//  with the first divider stage, then 15 more divider stages and the output queue.
//  in_stall rises only when 32 averages are pending between input and output.
//  Reset clears control state only; the sum RAM is undefined until a
//  first-frame pixel loads an entry.
// ----------------------------------------------------------------------------
module frame_stack_averager
    import fsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [FC_BITS-1:0]     cfg_wr_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_BITS-1:0]    pixel_index,
    input  logic [SAMPLE_BITS-1:0] red_in,
    input  logic [SAMPLE_BITS-1:0] green_in,
    input  logic [SAMPLE_BITS-1:0] blue_in,
    input  logic                   first_frame,
    input  logic                   final_frame,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_BITS-1:0]    pixel_index_out,
    output logic [SUM_BITS-1:0]    red_avg,
    output logic [SUM_BITS-1:0]    green_avg,
    output logic [SUM_BITS-1:0]    blue_avg
);

    logic [FC_BITS-1:0]       frame_count_reg;
    logic [FC_BITS-1:0]       divisor;

    rgb_sum_t                 sum_mem [MAX_PIXELS];
    rgb_sum_t                 rd_data_reg;

    logic                     s1_valid_reg;
    logic [PIX_BITS-1:0]      s1_index_reg;
    rgb_sample_t              s1_sample_reg;
    logic                     s1_first_reg;
    logic                     s1_final_reg;

    logic                     fw_valid_reg;
    logic [PIX_BITS-1:0]      fw_index_reg;
    rgb_sum_t                 fw_sum_reg;

    rgb_sum_t                 old_sum;
    rgb_sum_t                 new_sum;

    logic                     div_valid;
    logic [PIX_BITS-1:0]      div_index;
    rgb_sum_t                 div_quo;

    result_t                  fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0]      fifo_cnt_reg;
    logic [CNT_BITS-1:0]      fifo_cnt_next;
    logic [CNT_BITS-1:0]      pend_reg;
    logic [CNT_BITS-1:0]      pend_next;

    logic                     in_xfer;
    logic                     out_xfer;
    result_t                  head;

    assign in_stall = (pend_reg == CNT_BITS'(FIFO_DEPTH));
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign divisor  = (frame_count_reg == '0) ? FC_BITS'(1) : frame_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FC_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            frame_count_reg <= cfg_wr_data;
        end
    end

    // read-modify-write of the sum RAM
    always_ff @(posedge clk)
    begin
        rd_data_reg <= sum_mem[pixel_index];
        if (s1_valid_reg)
        begin
            sum_mem[s1_index_reg] <= new_sum;
        end
    end

    always_comb
    begin
        logic [SUM_BITS:0] ext;
        old_sum = (fw_valid_reg && fw_index_reg == s1_index_reg) ? fw_sum_reg : rd_data_reg;
        for (int c = 0; c < CH_COUNT; c++)
        begin
            if (s1_first_reg)
            begin
                ext = (SUM_BITS+1)'(s1_sample_reg[c]);
            end
            else
            begin
                ext = {1'b0, old_sum[c]} + (SUM_BITS+1)'(s1_sample_reg[c]);
            end
            new_sum[c] = ext[SUM_BITS] ? {SUM_BITS{1'b1}} : ext[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            fw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg            <= pixel_index;
        s1_sample_reg[CH_RED]   <= red_in;
        s1_sample_reg[CH_GREEN] <= green_in;
        s1_sample_reg[CH_BLUE]  <= blue_in;
        s1_first_reg            <= first_frame;
        s1_final_reg            <= final_frame;
        fw_index_reg            <= s1_index_reg;
        fw_sum_reg              <= new_sum;
    end

    fsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg && s1_final_reg),
        .in_index  (s1_index_reg),
        .in_sum    (new_sum),
        .divisor   (divisor),
        .out_valid (div_valid),
        .out_index (div_index),
        .out_quo   (div_quo)
    );

    // output queue; pend counts averages in the sum update stage and the divider plus queued ones
    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (div_valid && !out_xfer)
        begin
            fifo_cnt_next = fifo_cnt_reg + CNT_BITS'(1);
        end
        else if (!div_valid && out_xfer)
        begin
            fifo_cnt_next = fifo_cnt_reg - CNT_BITS'(1);
        end

        pend_next = pend_reg;
        if (in_xfer && final_frame && !out_xfer)
        begin
            pend_next = pend_reg + CNT_BITS'(1);
        end
        else if (!(in_xfer && final_frame) && out_xfer)
        begin
            pend_next = pend_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (div_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_valid)
        begin
            fifo_mem[wr_ptr_reg].index <= div_index;
            fifo_mem[wr_ptr_reg].avg   <= div_quo;
        end
    end

    assign head            = fifo_mem[rd_ptr_reg];
    assign out_valid       = (fifo_cnt_reg != '0);
    assign pixel_index_out = head.index;
    assign red_avg         = head.avg[CH_RED];
    assign green_avg       = head.avg[CH_GREEN];
    assign blue_avg        = head.avg[CH_BLUE];

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_BITS'(FIFO_DEPTH))
        else $error("pending average count above queue depth");

    a_queue_within_pend: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= pend_reg)
        else $error("queue holds more averages than are pending");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> (fifo_cnt_reg != CNT_BITS'(FIFO_DEPTH)) || out_xfer)
        else $error("divider result pushed into a full queue");

    a_forward_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> fw_valid_reg && (fw_index_reg == $past(s1_index_reg)))
        else $error("forwarding register lost the last RAM write");
`endif

endmodule : frame_stack_averager
`default_nettype wire
